FILE: rtl/pbn_pkg.sv
package pbn_pkg;

  localparam int LANE_W   = 17;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_SOURCES = 7;

  // x / 32767 for x < 2^31 as (x * RECIP_M) >> RECIP_S
  localparam int RECIP_S = 46;
  localparam logic [31:0] RECIP_M = 32'(((64'd1 << RECIP_S) + 64'd32766) / 64'd32767);

  localparam logic [14:0] PINK_GAIN_RST   = 15'd8000;
  localparam logic [15:0] BROWN_ALPHA_RST = 16'd655;
  localparam logic [14:0] BROWN_GAIN_RST  = 15'd12000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_MODE  = 2'd0,
    CFG_PINK_GAIN   = 2'd1,
    CFG_BROWN_ALPHA = 2'd2,
    CFG_BROWN_GAIN  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic p_mul;
    logic p_acc;
    logic p_gain;
    logic p_recip;
    logic b_mul;
    logic b_upd;
    logic b_gain;
    logic fin;
  } pbn_cmd_t;

  typedef struct packed {
    logic mode;
    logic last_src;
  } pbn_status_t;

endpackage

FILE: rtl/pbn_ctrl.sv
module pbn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pbn_pkg::pbn_status_t status,
  output pbn_pkg::pbn_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_MUL,
    ST_P_ACC,
    ST_P_GAIN,
    ST_P_RECIP,
    ST_B_MUL,
    ST_B_UPD,
    ST_B_GAIN,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.mode ? ST_B_MUL : ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        cmd.p_mul = 1'b1;
        state_nxt = ST_P_ACC;
      end
      ST_P_ACC: begin
        cmd.p_acc = 1'b1;
        state_nxt = status.last_src ? ST_P_GAIN : ST_P_MUL;
      end
      ST_P_GAIN: begin
        cmd.p_gain = 1'b1;
        state_nxt  = ST_P_RECIP;
      end
      ST_P_RECIP: begin
        cmd.p_recip = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_B_MUL: begin
        cmd.b_mul = 1'b1;
        state_nxt = ST_B_UPD;
      end
      ST_B_UPD: begin
        cmd.b_upd = 1'b1;
        state_nxt = ST_B_GAIN;
      end
      ST_B_GAIN: begin
        cmd.b_gain = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/pbn_dp.sv
module pbn_dp #(
  parameter int NUM_SOURCES = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pbn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbn_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [pbn_pkg::LANE_W-1:0]          lanes [pbn_pkg::MAX_SOURCES],
  input  pbn_pkg::pbn_cmd_t                   cmd,
  output pbn_pkg::pbn_status_t                status,
  output logic signed [pbn_pkg::SAMPLE_W-1:0] out_sample
);

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int DIV_S = 20;
  localparam logic [20:0] DIV_M = 21'(((1 << DIV_S) + NUM_SOURCES - 1) / NUM_SOURCES);

  // configuration
  logic        mode_r;
  logic [14:0] pink_gain_r;
  logic [15:0] brown_alpha_r;
  logic [14:0] brown_gain_r;

  // persistent state
  logic [5:0]          counter_r;
  logic signed [17:0]  src_r [NUM_SOURCES];
  logic signed [31:0]  integ_r;

  // per-beat working registers
  logic [pbn_pkg::LANE_W-1:0] lane_r [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] mask_r;
  logic [IDX_W-1:0]       idx_r;
  logic [37:0]            div_prod_r;
  logic                   div_neg_r;
  logic signed [19:0]     sum_r;
  logic [30:0]            gain_prod_r;
  logic                   gain_neg_r;
  logic [62:0]            recip_r;
  logic signed [49:0]     bmul_r;
  logic signed [47:0]     bgain_r;
  logic signed [15:0]     out_r;

  logic [6:0]         cnt_ext;
  logic [6:0]         mask_full;
  logic [16:0]        lane_sel;
  logic signed [17:0] rv;
  logic [16:0]        rv_mag;
  logic [17:0]        div_q;
  logic signed [17:0] div_val;
  logic signed [17:0] src_add;
  logic               sum_neg;
  logic [16:0]        sum_mag;
  logic [31:0]        gain_full;
  logic [16:0]        recip_q;
  logic signed [15:0] pink_out;
  logic signed [15:0] white;
  logic signed [32:0] diff;
  logic signed [49:0] bmul_full;
  logic signed [49:0] bsum;
  logic signed [47:0] bgain_full;
  logic signed [47:0] btrunc;
  logic signed [17:0] bq;
  logic signed [15:0] brown_out;

  always_comb begin
    cnt_ext   = {1'b0, counter_r};
    mask_full = cnt_ext ^ (cnt_ext + 7'd1);

    lane_sel = lane_r[idx_r];
    rv       = $signed({1'b0, lane_sel}) - 18'sd65536;
    rv_mag   = rv[17] ? 17'(-rv) : rv[16:0];
    div_q    = 18'(div_prod_r >> DIV_S);
    div_val  = div_neg_r ? -$signed(div_q) : $signed(div_q);
    src_add  = mask_r[idx_r] ? div_val : src_r[idx_r];

    sum_neg   = sum_r[19];
    sum_mag   = sum_neg ? 17'(-sum_r) : sum_r[16:0];
    gain_full = 32'(sum_mag * pink_gain_r);
    recip_q   = 17'(recip_r >> pbn_pkg::RECIP_S);
    if (!gain_neg_r) begin
      pink_out = (recip_q > 17'd32767) ? 16'sh7fff : $signed(recip_q[15:0]);
    end else begin
      pink_out = (recip_q > 17'd32768) ? 16'sh8000 : $signed(16'(-recip_q));
    end

    white      = $signed({~lane_r[0][15], lane_r[0][14:0]});
    diff       = $signed({{2{white[15]}}, white, 15'd0}) - $signed({integ_r[31], integ_r});
    bmul_full  = $signed({1'b0, brown_alpha_r}) * diff;
    bsum       = bmul_r + $signed({{2{integ_r[31]}}, integ_r, 16'd0});
    bgain_full = integ_r * $signed({1'b0, brown_gain_r});
    btrunc     = bgain_r + (bgain_r[47] ? 48'sd1073741823 : 48'sd0);
    bq         = btrunc[47:30];
    if (bq > 18'sd32767) begin
      brown_out = 16'sh7fff;
    end else if (bq < -18'sd32768) begin
      brown_out = 16'sh8000;
    end else begin
      brown_out = bq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b0;
      pink_gain_r   <= pbn_pkg::PINK_GAIN_RST;
      brown_alpha_r <= pbn_pkg::BROWN_ALPHA_RST;
      brown_gain_r  <= pbn_pkg::BROWN_GAIN_RST;
      counter_r     <= '0;
      integ_r       <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        src_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (pbn_pkg::cfg_idx_t'(cfg_index))
          pbn_pkg::CFG_NOISE_MODE:  mode_r        <= cfg_wdata[0];
          pbn_pkg::CFG_PINK_GAIN:   pink_gain_r   <= cfg_wdata[14:0];
          pbn_pkg::CFG_BROWN_ALPHA: brown_alpha_r <= cfg_wdata[15:0];
          pbn_pkg::CFG_BROWN_GAIN:  brown_gain_r  <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (cmd.load && !mode_r) begin
        counter_r <= counter_r + 6'd1;
      end
      if (cmd.p_acc && mask_r[idx_r]) begin
        src_r[idx_r] <= div_val;
      end
      if (cmd.b_upd) begin
        integ_r <= bsum[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        lane_r[i] <= lanes[i];
      end
      mask_r <= mask_full[NUM_SOURCES-1:0];
      idx_r  <= '0;
      sum_r  <= '0;
    end
    if (cmd.p_mul) begin
      div_prod_r <= 38'(rv_mag * DIV_M);
      div_neg_r  <= rv[17];
    end
    if (cmd.p_acc) begin
      sum_r <= sum_r + 20'(src_add);
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.p_gain) begin
      gain_prod_r <= gain_full[30:0];
      gain_neg_r  <= sum_neg;
    end
    if (cmd.p_recip) begin
      recip_r <= 63'(gain_prod_r * pbn_pkg::RECIP_M);
    end
    if (cmd.b_mul) begin
      bmul_r <= bmul_full;
    end
    if (cmd.b_gain) begin
      bgain_r <= bgain_full;
    end
    if (cmd.fin) begin
      out_r <= mode_r ? brown_out : pink_out;
    end
  end

  assign status.mode     = mode_r;
  assign status.last_src = (idx_r == IDX_W'(NUM_SOURCES - 1));
  assign out_sample      = out_r;

endmodule

FILE: rtl/pink_brown_noise_generator.sv
// Pink path: load, then per source a multiply and an accumulate state, then gain, reciprocal and
// finish; brown path: load, multiply, integrator update, gain and finish. A new beat is accepted
// only in idle, once the previous one is finished; the pink path shares one divide-by-source-count multiplier.
// A finished sample waits in the output register while the next beat is accepted.
// Reset (synchronous, active low) clears sources, counter and integrator and loads
// default gains; the block is ready the cycle after reset is released.
module pink_brown_noise_generator #(
  parameter int NUM_SOURCES = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pbn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbn_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane0,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane1,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane2,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane3,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane4,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane5,
  input  logic [pbn_pkg::LANE_W-1:0]          in_rand_lane6,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pbn_pkg::SAMPLE_W-1:0] out_noise_sample
);

  logic [pbn_pkg::LANE_W-1:0] lanes [pbn_pkg::MAX_SOURCES];
  pbn_pkg::pbn_cmd_t    cmd;
  pbn_pkg::pbn_status_t status;

  assign lanes[0] = in_rand_lane0;
  assign lanes[1] = in_rand_lane1;
  assign lanes[2] = in_rand_lane2;
  assign lanes[3] = in_rand_lane3;
  assign lanes[4] = in_rand_lane4;
  assign lanes[5] = in_rand_lane5;
  assign lanes[6] = in_rand_lane6;

  pbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pbn_dp #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .lanes      (lanes),
    .cmd        (cmd),
    .status     (status),
    .out_sample (out_noise_sample)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

endmodule
